FILE: hw/rtl/swm_pkg.sv
// shared types and constants for the sliding window median core
// no dependencies; used by the controller, datapath and top level
`timescale 1ns / 1ps

package swm_pkg;

  // default sizes of the window and of one sample
  localparam int WINDOW_MAX_DEF   = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // window size register
  localparam int CFG_W            = 5;
  localparam int WINDOW_RESET     = 5;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the incoming sample
    logic store;     // write the sample; when full, drop the oldest sorted entry
    logic insert;    // insert the sample into the sorted list
    logic publish;   // load the output register with the middle entry
  } swm_cmd_t;

endpackage

FILE: hw/rtl/sliding_window_median_core.sv
// top level of the running median filter: controller plus datapath
// depends on swm_pkg, swm_controller, swm_datapath (and swm_ram below it)
`timescale 1ns / 1ps
//
// channel    dir   handshake          payload
// s_*        in    tvalid / tready    tdata: sample (signed)
// m_*        out   tvalid / tready    tdata: median (signed)
// cfg_*      in    cfg_we only        cfg_wdata: window size, 5 bits
//
// one word passes these steps from acceptance to the output register:
// accept, store (window write and, once the window is full, removal of the oldest
// entry from the sorted list), insert (new sample into the sorted list), publish
// the sorted list is a row of compare lanes, so the number of steps does not
// depend on the window size; the next word is taken once publish has fired
// a result waiting on m_* holds publish back only when a second one is ready
// synchronous active high reset: window size 5, window empty
// a write on cfg_* empties the window and sets the new size (0 acts as 1)

module sliding_window_median_core #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // [SAMPLE_WIDTH-1:0] sample
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,  // [SAMPLE_WIDTH-1:0] median
  // window size register
  input  logic                              cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  swm_pkg::swm_cmd_t       cmd;
  logic [SAMPLE_WIDTH-1:0] median;

  // sequencing and output valid
  swm_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // window, sorted lanes and output register
  swm_datapath #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sample    (s_tdata[SAMPLE_WIDTH-1:0]),
    .median    (median)
  );

  // zero padding up to whole bytes
  assign m_tdata = TDATA_W'(median);

endmodule

FILE: hw/rtl/swm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module swm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/swm_controller.sv
// sequencing state machine and output handshake for the median core
// depends on swm_pkg
`timescale 1ns / 1ps

module swm_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output swm_pkg::swm_cmd_t cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_STORE   = 2'd1;
  localparam logic [1:0] S_INSERT  = 2'd2;
  localparam logic [1:0] S_PUBLISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_PUBLISH;
      end
      S_PUBLISH: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_accept_to_store: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_STORE))
    else $error("accepted word did not move to the store step");

  a_insert_to_publish: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |=> (state == S_PUBLISH))
    else $error("insert step not followed by publish");

  a_publish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> m_tvalid)
    else $error("published word not offered");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.store, cmd.insert, cmd.publish}))
    else $error("more than one datapath command at once");

endmodule

FILE: hw/rtl/swm_datapath.sv
// window store, sorted list of the window, counters and output register
// depends on swm_pkg and swm_ram
`timescale 1ns / 1ps

module swm_datapath #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata,
  input  swm_pkg::swm_cmd_t        cmd,
  input  logic [SAMPLE_WIDTH-1:0]  sample,
  output logic [SAMPLE_WIDTH-1:0]  median
);

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SIZE_RESET = (swm_pkg::WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                                   : swm_pkg::WINDOW_RESET;

  logic [SAMPLE_WIDTH-1:0] sample_q;
  logic [CNT_W-1:0]        size_q;
  logic [CNT_W-1:0]        count_q;
  logic [PTR_W-1:0]        wptr_q;
  logic [SAMPLE_WIDTH-1:0] sorted [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] sorted_next [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] oldest;
  logic [WINDOW_MAX-1:0]   above;
  logic                    full;
  logic [CNT_W-1:0]        wptr_inc;
  logic [CNT_W-1:0]        size_next;
  logic [CNT_W-1:0]        mid;

  // circular window store
  swm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (WINDOW_MAX)
  ) u_window (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (wptr_q),
    .wdata (sample_q),
    .raddr (wptr_q),
    .rdata (oldest)
  );

  assign full     = (count_q == size_q);
  assign wptr_inc = CNT_W'(wptr_q) + CNT_W'(1);
  assign mid      = count_q >> 1;

  // written size: zero acts as one, oversize clamps
  always_comb begin
    if (cfg_wdata == '0) begin
      size_next = CNT_W'(1);
    end else if (int'(cfg_wdata) > WINDOW_MAX) begin
      size_next = CNT_W'(WINDOW_MAX);
    end else begin
      size_next = CNT_W'(cfg_wdata);
    end
  end

  // lane logic: delete the oldest entry or insert the new sample
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      above[i] = (CNT_W'(i) >= count_q) || ($signed(sorted[i]) > $signed(sample_q));
    end
    for (int i = 0; i < WINDOW_MAX; i++) begin
      sorted_next[i] = sorted[i];
      if (cmd.store && full) begin
        if (!($signed(sorted[i]) < $signed(oldest)) && (i < WINDOW_MAX - 1)) begin
          sorted_next[i] = sorted[(i < WINDOW_MAX - 1) ? i + 1 : i];
        end
      end else if (cmd.insert) begin
        if (above[i]) begin
          if (i > 0 && above[(i > 0) ? i - 1 : 0]) begin
            sorted_next[i] = sorted[(i > 0) ? i - 1 : 0];
          end else begin
            sorted_next[i] = sample_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      sorted[i] <= sorted_next[i];
    end
    if (cmd.capture) begin
      sample_q <= sample;
    end
    if (cmd.publish) begin
      median <= sorted[mid[PTR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_q  <= CNT_W'(SIZE_RESET);
      count_q <= '0;
      wptr_q  <= '0;
    end else if (cfg_we) begin
      size_q  <= size_next;
      count_q <= '0;
      wptr_q  <= '0;
    end else if (cmd.store) begin
      if (full) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (wptr_inc >= size_q) begin
        wptr_q <= '0;
      end else begin
        wptr_q <= wptr_inc[PTR_W-1:0];
      end
    end else if (cmd.insert) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_q <= size_q)
    else $error("fill count beyond window size");

  a_wptr_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(wptr_q) < size_q)
    else $error("write position beyond window size");

  a_publish_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (count_q != '0))
    else $error("median taken over an empty window");

endmodule
